@@ sv/mpmd_pkg.sv @@
// ----------------------------------------------------------------------------
// mpmd_pkg
// Shared types, codes and the radix-4 modular reduction step.
// ----------------------------------------------------------------------------
package mpmd_pkg;

	localparam int MOD_W  = 31;
	localparam int OPND_W = 63;
	localparam int ACT_W  = 2;
	localparam int SH_W   = 64;
	localparam int CNT_W  = 5;
	localparam int ADDR_W = 3;

	localparam logic [MOD_W-1:0] MOD_RESET = 31'd1000000007;
	localparam logic [MOD_W-1:0] MOD_ONE   = 31'd1;
	localparam logic [MOD_W-1:0] MOD_TWO   = 31'd2;
	localparam logic [CNT_W-1:0] CNT_LAST  = 5'd31;

	// action codes
	localparam logic [ACT_W-1:0] ACT_POW  = 2'd0;
	localparam logic [ACT_W-1:0] ACT_MUL  = 2'd1;
	localparam logic [ACT_W-1:0] ACT_DIV  = 2'd2;
	localparam logic [ACT_W-1:0] ACT_NONE = 2'd3;

	// result source codes
	localparam logic [1:0] OUT_ACC  = 2'd0;
	localparam logic [1:0] OUT_ZERO = 2'd1;
	localparam logic [1:0] OUT_ERR  = 2'd2;

	typedef struct packed {
		logic             load;
		logic             step;
		logic             setup;
		logic             mul;
		logic             update;
		logic             take;
		logic             fin_setup;
		logic             out_load;
		logic [ACT_W-1:0] act;
		logic [1:0]       out_kind;
	} cmd_t;

	typedef struct packed {
		logic mod_small;
		logic r1_zero;
		logic exp_zero;
	} stat_t;

	// r < m on entry; returns (4r + d) mod m with one three-way compare
	function automatic logic [MOD_W-1:0] red_step(
		input logic [MOD_W-1:0] r,
		input logic [1:0]       d,
		input logic [MOD_W-1:0] m,
		input logic [MOD_W+1:0] m3
	);
		logic [MOD_W+1:0] t;
		logic [MOD_W+1:0] m1;
		logic [MOD_W+1:0] m2;
		logic [MOD_W+1:0] res;
		t  = {r, d};
		m1 = {2'b00, m};
		m2 = {1'b0, m, 1'b0};
		if (t >= m3) begin
			res = t - m3;
		end else if (t >= m2) begin
			res = t - m2;
		end else if (t >= m1) begin
			res = t - m1;
		end else begin
			res = t;
		end
		return res[MOD_W-1:0];
	endfunction

endpackage

@@ sv/mpmd_if.sv @@
// ----------------------------------------------------------------------------
// mpmd_in_if / mpmd_out_if
// Valid/ready channels for request and result items.
// ----------------------------------------------------------------------------
interface mpmd_in_if import mpmd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ACT_W-1:0]  action;
	logic [OPND_W-1:0] operand_a;
	logic [OPND_W-1:0] operand_b;

	modport source(output valid, action, operand_a, operand_b, input ready);
	modport sink(input valid, action, operand_a, operand_b, output ready);
endinterface

interface mpmd_out_if import mpmd_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [MOD_W-1:0] value;
	logic             error;

	modport source(output valid, value, error, input ready);
	modport sink(input valid, value, error, output ready);
endinterface

@@ sv/modular_pow_mul_div_unit.sv @@
// ----------------------------------------------------------------------------
// modular_pow_mul_div_unit
// One item at a time; every reduction runs the radix-4 lanes for 32 steps.
// Multiply: reduce both operands, then one product. Power: one multiply per
// exponent bit. Divide: power of b to modulus-2, then a product with a.
// Next item can be taken in the cycle after the result enters the out reg.
// arst_n clears control and sets modulus to 1000000007.
// ----------------------------------------------------------------------------
module modular_pow_mul_div_unit import mpmd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	// configuration
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	// items
	mpmd_in_if.sink           in_ch,
	mpmd_out_if.source        out_ch
);

	logic [MOD_W-1:0] modulus_q;
	logic             reg_sel;
	logic             wr_en;
	cmd_t             cmd;
	stat_t            stat;

	// register 0 at byte address 0; any other word address is ignored
	assign reg_sel = (paddr[ADDR_W-1:2] == '0);
	assign wr_en   = psel && penable && pwrite && reg_sel;
	assign pready  = 1'b1;
	assign prdata  = reg_sel ? {1'b0, modulus_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= MOD_RESET;
		end else if (wr_en) begin
			modulus_q <= pwdata[MOD_W-1:0];
		end
	end

	// sequencer: reduce both operands, run square-and-multiply, final product
	mpmd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_action (in_ch.action),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// arithmetic: two 31x31 multipliers feeding two 2-bit/cycle reducers
	mpmd_dpath u_dpath (
		.clk       (clk),
		.modulus   (modulus_q),
		.operand_a (in_ch.operand_a),
		.operand_b (in_ch.operand_b),
		.cmd       (cmd),
		.stat      (stat),
		.value     (out_ch.value),
		.error     (out_ch.error)
	);

endmodule

@@ sv/mpmd_dpath.sv @@
// ----------------------------------------------------------------------------
// mpmd_dpath
// Two reduction lanes, two multipliers and the exponent/accumulator regs.
// ----------------------------------------------------------------------------
module mpmd_dpath import mpmd_pkg::*; (
	input  logic              clk,
	input  logic [MOD_W-1:0]  modulus,
	input  logic [OPND_W-1:0] operand_a,
	input  logic [OPND_W-1:0] operand_b,
	input  cmd_t              cmd,
	output stat_t             stat,
	output logic [MOD_W-1:0]  value,
	output logic              error
);

	logic [SH_W-1:0]   sh0_q, sh1_q;
	logic [MOD_W-1:0]  r0_q, r1_q;
	logic [OPND_W-1:0] b_raw_q;
	logic [OPND_W-1:0] exp_q;
	logic [MOD_W-1:0]  ar_q, acc_q, sq_q;
	logic [MOD_W+1:0]  m3_q;
	logic [MOD_W-1:0]  value_q;
	logic              error_q;
	logic [2*MOD_W-1:0] p0, p1;

	assign p0 = acc_q * sq_q;
	assign p1 = sq_q * sq_q;

	assign stat.mod_small = (modulus[MOD_W-1:1] == '0);
	assign stat.r1_zero   = (r1_q == '0);
	assign stat.exp_zero  = (exp_q == '0);

	assign value = value_q;
	assign error = error_q;

	// 3m for the reduction compare; the user must change the modulus only while idle, the block does not enforce it
	always_ff @(posedge clk) begin
		m3_q <= {2'b00, modulus} + {1'b0, modulus, 1'b0};
	end

	// reduction lanes
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sh0_q   <= {1'b0, operand_a};
			sh1_q   <= {1'b0, operand_b};
			r0_q    <= '0;
			r1_q    <= '0;
			b_raw_q <= operand_b;
		end else if (cmd.mul) begin
			sh0_q <= {2'b00, p0};
			sh1_q <= {2'b00, p1};
			r0_q  <= '0;
			r1_q  <= '0;
		end else if (cmd.step) begin
			sh0_q <= {sh0_q[SH_W-3:0], 2'b00};
			sh1_q <= {sh1_q[SH_W-3:0], 2'b00};
			r0_q  <= red_step(r0_q, sh0_q[SH_W-1:SH_W-2], modulus, m3_q);
			r1_q  <= red_step(r1_q, sh1_q[SH_W-1:SH_W-2], modulus, m3_q);
		end
	end

	// accumulator, square and exponent
	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			ar_q <= r0_q;
			unique case (cmd.act)
				ACT_POW: begin
					acc_q <= MOD_ONE;
					sq_q  <= r0_q;
					exp_q <= b_raw_q;
				end
				ACT_MUL: begin
					acc_q <= r0_q;
					sq_q  <= r1_q;
				end
				ACT_DIV: begin
					acc_q <= MOD_ONE;
					sq_q  <= r1_q;
					exp_q <= {{(OPND_W-MOD_W){1'b0}}, modulus - MOD_TWO};
				end
				default: begin
				end
			endcase
		end else if (cmd.update) begin
			if (exp_q[0]) begin
				acc_q <= r0_q;
			end
			sq_q  <= r1_q;
			exp_q <= {1'b0, exp_q[OPND_W-1:1]};
		end else if (cmd.take) begin
			acc_q <= r0_q;
		end else if (cmd.fin_setup) begin
			sq_q <= ar_q;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			value_q <= (cmd.out_kind == OUT_ACC) ? acc_q : '0;
			error_q <= (cmd.out_kind == OUT_ERR);
		end
	end

endmodule

@@ sv/mpmd_ctrl.sv @@
// ----------------------------------------------------------------------------
// mpmd_ctrl
// Sequencer: operand reduction, square-and-multiply loop, final product.
// ----------------------------------------------------------------------------
module mpmd_ctrl import mpmd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [ACT_W-1:0] in_action,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  stat_t            stat,
	output cmd_t             cmd
);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_RED    = 4'd1;
	localparam logic [3:0] ST_SETUP  = 4'd2;
	localparam logic [3:0] ST_PCHK   = 4'd3;
	localparam logic [3:0] ST_PMUL   = 4'd4;
	localparam logic [3:0] ST_PRED   = 4'd5;
	localparam logic [3:0] ST_PUPD   = 4'd6;
	localparam logic [3:0] ST_FSETUP = 4'd7;
	localparam logic [3:0] ST_FMUL   = 4'd8;
	localparam logic [3:0] ST_FRED   = 4'd9;
	localparam logic [3:0] ST_FTAKE  = 4'd10;
	localparam logic [3:0] ST_DONE   = 4'd11;

	logic [3:0]       state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [ACT_W-1:0] act_q, act_d;
	logic [1:0]       kind_q, kind_d;
	logic             out_valid_q;
	logic             accept;
	logic             out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d      = state_q;
		cnt_d        = cnt_q;
		act_d        = act_q;
		kind_d       = kind_q;
		cmd          = '0;
		cmd.act      = act_q;
		cmd.out_kind = kind_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.load = 1'b1;
					act_d    = in_action;
					cnt_d    = '0;
					if (stat.mod_small || in_action == ACT_NONE) begin
						kind_d  = (stat.mod_small && in_action == ACT_DIV) ? OUT_ERR : OUT_ZERO;
						state_d = ST_DONE;
					end else begin
						state_d = ST_RED;
					end
				end
			end
			ST_RED: begin
				cmd.step = 1'b1;
				cnt_d    = cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					state_d = ST_SETUP;
				end
			end
			ST_SETUP: begin
				cmd.setup = 1'b1;
				kind_d    = OUT_ACC;
				priority if (act_q == ACT_MUL) begin
					state_d = ST_FMUL;
				end else if (act_q == ACT_DIV && stat.r1_zero) begin
					kind_d  = OUT_ERR;
					state_d = ST_DONE;
				end else begin
					state_d = ST_PCHK;
				end
			end
			ST_PCHK: begin
				if (stat.exp_zero) begin
					state_d = (act_q == ACT_DIV) ? ST_FSETUP : ST_DONE;
				end else begin
					state_d = ST_PMUL;
				end
			end
			ST_PMUL: begin
				cmd.mul = 1'b1;
				cnt_d   = '0;
				state_d = ST_PRED;
			end
			ST_PRED: begin
				cmd.step = 1'b1;
				cnt_d    = cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					state_d = ST_PUPD;
				end
			end
			ST_PUPD: begin
				cmd.update = 1'b1;
				state_d    = ST_PCHK;
			end
			ST_FSETUP: begin
				cmd.fin_setup = 1'b1;
				state_d       = ST_FMUL;
			end
			ST_FMUL: begin
				cmd.mul = 1'b1;
				cnt_d   = '0;
				state_d = ST_FRED;
			end
			ST_FRED: begin
				cmd.step = 1'b1;
				cnt_d    = cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					state_d = ST_FTAKE;
				end
			end
			ST_FTAKE: begin
				cmd.take = 1'b1;
				state_d  = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			act_q       <= ACT_POW;
			kind_q      <= OUT_ZERO;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			act_q   <= act_d;
			kind_q  <= kind_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTH
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result raised outside DONE");

	a_red_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PMUL || state_q == ST_FMUL) |=> (cnt_q == '0))
		else $error("reduction count not restarted after multiply");

	a_red_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RED && cnt_q == CNT_LAST) |=> (state_q == ST_SETUP))
		else $error("operand reduction did not end after 32 steps");

	a_busy_no_take: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !cmd.load)
		else $error("operand load while busy");
`endif

endmodule

@@ sim/mpmd_result_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpmd_result_checker
// Watches register writes and both item channels, predicts each result from
// the operands and the live modulus, and compares the results in order.
// ----------------------------------------------------------------------------
module mpmd_result_checker import mpmd_pkg::*; #(
	parameter logic [ADDR_W-1:0] MOD_ADDR = '0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic              pready,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	input  logic              req_valid,
	input  logic              req_ready,
	input  logic [ACT_W-1:0]  req_action,
	input  logic [OPND_W-1:0] req_a,
	input  logic [OPND_W-1:0] req_b,
	input  logic              res_valid,
	input  logic              res_ready,
	input  logic [MOD_W-1:0]  res_value,
	input  logic              res_error,
	output int                fault_count,
	output int                outstanding
);

	typedef struct packed {
		logic [MOD_W-1:0] value;
		logic             error;
	} mod_result_t;

	logic [MOD_W-1:0] modulus_q;
	mod_result_t      expected_q[$];
	mod_result_t      want;

	// square-and-multiply over every bit of the exponent; operands stay below 2^31
	function automatic logic [63:0] mod_power(
		input logic [63:0]       base,
		input logic [OPND_W-1:0] ex,
		input logic [63:0]       m
	);
		logic [63:0]       acc;
		logic [63:0]       sq;
		logic [OPND_W-1:0] e;
		acc = 64'd1 % m;
		sq  = base % m;
		e   = ex;
		while (e != '0) begin
			if (e[0]) begin
				acc = (acc * sq) % m;
			end
			sq = (sq * sq) % m;
			e  = e >> 1;
		end
		return acc;
	endfunction

	function automatic mod_result_t predict_result(
		input logic [ACT_W-1:0]  act,
		input logic [OPND_W-1:0] a,
		input logic [OPND_W-1:0] b,
		input logic [MOD_W-1:0]  mod
	);
		logic [63:0] m;
		logic [63:0] inv;
		mod_result_t r;
		m = 64'(mod);
		r = '0;
		if (m < 64'd2) begin
			// degenerate modulus: everything is zero, divide always faults
			if (act == ACT_DIV) begin
				r.error = 1'b1;
			end
		end else begin
			case (act)
				ACT_POW: begin
					r.value = MOD_W'(mod_power(64'(a), b, m));
				end
				ACT_MUL: begin
					r.value = MOD_W'(((64'(a) % m) * (64'(b) % m)) % m);
				end
				ACT_DIV: begin
					if ((64'(b) % m) == 64'd0) begin
						r.error = 1'b1;
					end else begin
						inv     = mod_power(64'(b), OPND_W'(m - 64'd2), m);
						r.value = MOD_W'(((64'(a) % m) * inv) % m);
					end
				end
				default: begin
				end
			endcase
		end
		return r;
	endfunction

	task automatic report_fault(input string msg);
		$display("%0t ns mismatch: %s", $time, msg);
		fault_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q = MOD_RESET;
			expected_q.delete();
		end else begin
			if (psel && penable && pwrite && pready && paddr == MOD_ADDR) begin
				modulus_q = pwdata[MOD_W-1:0];
			end
			if (res_valid && res_ready) begin
				if (expected_q.size() == 0) begin
					report_fault($sformatf("result value %0d error %0b with none expected",
						res_value, res_error));
				end else begin
					want = expected_q.pop_front();
					if (res_value !== want.value) begin
						report_fault($sformatf("value %0d, expected %0d", res_value, want.value));
					end
					if (res_error !== want.error) begin
						report_fault($sformatf("error %0b, expected %0b", res_error, want.error));
					end
				end
			end
			if (req_valid && req_ready) begin
				// append at the tail
				expected_q.insert(expected_q.size(),
					predict_result(req_action, req_a, req_b, modulus_q));
			end
		end
		outstanding = expected_q.size();
	end

endmodule

@@ sim/tb_modular_pow_mul_div_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_modular_pow_mul_div_unit
// Drives power, multiply and divide items through the unit across a range of
// moduli, including the degenerate ones, with random idling on both channels
// and one long output stall; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_modular_pow_mul_div_unit;
	import mpmd_pkg::*;

	localparam int HALF_PERIOD    = 10;
	localparam int RESET_CYCLES   = 12;
	// allow for the longest power item plus the output hold-off on top
	localparam int QUIET_LIMIT    = 20000;
	localparam int HOLD_CYCLES    = 800;
	localparam int SETTLE_CYCLES  = 100;
	localparam int PHASES         = 9;
	localparam int PHASE_ITEMS    = 28;
	localparam int PRESSURE_ITEMS = 12;
	localparam int PRESSURE_PHASE = 6;

	localparam logic [ADDR_W-1:0] MODULUS_ADDR = 3'd0;
	localparam logic [ADDR_W-1:0] SPARE_ADDR   = 3'd4;  // no register here
	localparam logic [OPND_W-1:0] OPND_MAX     = '1;
	localparam logic [MOD_W-1:0]  MOD_MAX      = '1;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;

	mpmd_in_if  req_ch();
	mpmd_out_if res_ch();

	// idle odds in percent, changed by the random phases
	int snd_idle = 24;
	int rcv_idle = 64;
	// bumping hold_asks makes the receiver stall, holding ready low
	int hold_asks = 0;
	int hold_seen = 0;
	int fault_count;
	int outstanding;
	int quiet_cycles = 0;
	logic [MOD_W-1:0] cur_mod;

	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	modular_pow_mul_div_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.in_ch   (req_ch),
		.out_ch  (res_ch)
	);

	mpmd_result_checker #(
		.MOD_ADDR (MODULUS_ADDR)
	) checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.pready      (pready),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.req_valid   (req_ch.valid),
		.req_ready   (req_ch.ready),
		.req_action  (req_ch.action),
		.req_a       (req_ch.operand_a),
		.req_b       (req_ch.operand_b),
		.res_valid   (res_ch.valid),
		.res_ready   (res_ch.ready),
		.res_value   (res_ch.value),
		.res_error   (res_ch.error),
		.fault_count (fault_count),
		.outstanding (outstanding)
	);

	// watchdog: any accepted item on either channel counts as progress
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// result side: random ready, or a long hold-off when asked for
	initial begin
		res_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_seen != hold_asks) begin
				hold_seen = hold_asks;
				res_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				res_ch.ready <= ($urandom_range(99) >= rcv_idle);
			end
		end
	end

	// offer one item, with random gaps first; returns on the accepting edge
	// with valid still high so back-to-back items need no extra step
	task automatic send_item(
		input logic [ACT_W-1:0]  act,
		input logic [OPND_W-1:0] a,
		input logic [OPND_W-1:0] b
	);
		while ($urandom_range(99) < snd_idle) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.action    <= act;
		req_ch.operand_a <= a;
		req_ch.operand_b <= b;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
	endtask

	// stop offering and wait until every predicted result has come back
	task automatic drain();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		wait (outstanding == 0);
	endtask

	// setup cycle then access cycle; register lands when pready is seen
	task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic set_modulus(input logic [MOD_W-1:0] m);
		drain();
		write_reg(MODULUS_ADDR, {1'b0, m});
		cur_mod = m;
	endtask

	function automatic logic [OPND_W-1:0] rand_operand();
		logic [63:0] t;
		t = {$urandom, $urandom};
		return t[OPND_W-1:0];
	endfunction

	// a random multiple of the live modulus, zero included
	function automatic logic [OPND_W-1:0] mod_multiple();
		logic [63:0] t;
		t = 64'(cur_mod) * 64'($urandom);
		return t[OPND_W-1:0];
	endfunction

	function automatic logic [MOD_W-1:0] phase_modulus(input int phase);
		case (phase)
			0: return MOD_RESET;
			1: return 31'd998244353;
			2: return 31'h4000_0000 | MOD_W'($urandom);
			3: return MOD_MAX;
			4: return MOD_W'($urandom_range(1000, 2));
			5: return 31'd65537;
			7: return 31'd3;
			default: return MOD_W'($urandom_range(32'h7FFF_FFFF, 2));
		endcase
	endfunction

	// mostly real work; a few unused action codes as noise
	task automatic send_random();
		logic [ACT_W-1:0]  act;
		logic [OPND_W-1:0] a;
		logic [OPND_W-1:0] b;
		int                pick;
		int                len;
		pick = $urandom_range(99);
		if (pick < 38) begin
			act = ACT_POW;
		end else if (pick < 68) begin
			act = ACT_MUL;
		end else if (pick < 93) begin
			act = ACT_DIV;
		end else begin
			act = ACT_NONE;
		end
		a = rand_operand();
		b = rand_operand();
		case ($urandom_range(9))
			0: a = mod_multiple();
			1: a = OPND_W'($urandom_range(3));
			default: begin
			end
		endcase
		if (act == ACT_POW) begin
			// spread exponent length so run time stays reasonable
			len = $urandom_range(OPND_W);
			b   = b >> (OPND_W - len);
		end else if (act == ACT_DIV && $urandom_range(9) == 0) begin
			b = mod_multiple();
		end
		send_item(act, a, b);
	endtask

	initial begin
		arst_n           = 1'b0;
		psel             = 1'b0;
		penable          = 1'b0;
		pwrite           = 1'b0;
		paddr            = '0;
		pwdata           = '0;
		req_ch.valid     = 1'b0;
		req_ch.action    = ACT_POW;
		req_ch.operand_a = '0;
		req_ch.operand_b = '0;
		cur_mod          = MOD_RESET;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset modulus, operand extremes, zero exponent, bad divisors
		send_item(ACT_POW, 63'd2, 63'd10);
		send_item(ACT_POW, OPND_MAX, '0);
		send_item(ACT_POW, '0, '0);
		send_item(ACT_POW, OPND_MAX, OPND_MAX);
		send_item(ACT_POW, OPND_W'(MOD_RESET - 31'd1), 63'd1);
		send_item(ACT_MUL, OPND_MAX, OPND_MAX);
		send_item(ACT_MUL, '0, OPND_MAX);
		send_item(ACT_MUL, OPND_W'(MOD_RESET), 63'd5);
		send_item(ACT_DIV, 63'd10, 63'd3);
		send_item(ACT_DIV, 63'd5, '0);
		send_item(ACT_DIV, 63'd7, OPND_W'(MOD_RESET));
		send_item(ACT_DIV, OPND_MAX, OPND_MAX);
		send_item(ACT_DIV, '0, 63'd1);
		send_item(ACT_NONE, OPND_MAX, OPND_MAX);
		send_item(ACT_NONE, '0, '0);

		// write to an unmapped index must leave the modulus alone
		drain();
		write_reg(SPARE_ADDR, '1);
		send_item(ACT_POW, 63'd3, 63'd5);

		// smallest legal modulus: exponent m-2 is zero on divide
		set_modulus(MOD_TWO);
		send_item(ACT_POW, OPND_MAX, OPND_MAX);
		send_item(ACT_MUL, 63'd3, 63'd3);
		send_item(ACT_DIV, 63'd1, 63'd1);
		send_item(ACT_DIV, 63'd3, 63'd2);

		// largest modulus
		set_modulus(MOD_MAX);
		send_item(ACT_POW, OPND_MAX, OPND_MAX);
		send_item(ACT_MUL, OPND_MAX, OPND_MAX);
		send_item(ACT_DIV, OPND_MAX, OPND_MAX);

		// modulus below two: all zero, divide flags error
		set_modulus(MOD_ONE);
		send_item(ACT_POW, 63'd5, 63'd5);
		send_item(ACT_DIV, 63'd5, 63'd3);
		set_modulus('0);
		send_item(ACT_MUL, 63'd5, 63'd5);
		send_item(ACT_DIV, 63'd5, '0);
		send_item(ACT_NONE, OPND_MAX, OPND_MAX);

		// random phases: sender-light idling, then receiver-light, then none
		for (int phase = 0; phase < PHASES; phase++) begin
			if (phase == 3) begin
				snd_idle = 64;
				rcv_idle = 24;
			end
			if (phase == PRESSURE_PHASE) begin
				snd_idle = 0;
				rcv_idle = 0;
			end
			set_modulus(phase_modulus(phase));
			if (phase == PRESSURE_PHASE) begin
				// output blocked while short multiplies keep coming: input backs up
				hold_asks++;
				repeat (PRESSURE_ITEMS) send_item(ACT_MUL, rand_operand(), rand_operand());
			end
			repeat (PHASE_ITEMS) send_random();
		end

		drain();
		// catch any stray result after the last expected one
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fault_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

@@ sim.f @@
sv/mpmd_pkg.sv
sv/mpmd_if.sv
sv/mpmd_dpath.sv
sv/mpmd_ctrl.sv
sv/modular_pow_mul_div_unit.sv
sim/mpmd_result_checker.sv
sim/tb_modular_pow_mul_div_unit.sv
